// ===== sv/lpvd_pkg.sv =====
package lpvd_pkg;

	// input opcodes
	localparam logic [1:0] OPC_START = 2'd0;
	localparam logic [1:0] OPC_RUN   = 2'd1;
	localparam logic [1:0] OPC_BYTE  = 2'd2;
	localparam logic [1:0] OPC_BAD   = 2'd3;

	// run kinds
	localparam logic [1:0] RK_CONTENT  = 2'd0;
	localparam logic [1:0] RK_NULL     = 2'd1;
	localparam logic [1:0] RK_FCONTENT = 2'd2;
	localparam logic [1:0] RK_FNULL    = 2'd3;

	// result kinds
	localparam logic [1:0] RES_DATA   = 2'd0;
	localparam logic [1:0] RES_EMPTY  = 2'd1;
	localparam logic [1:0] RES_STATUS = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_PREFIX = 2'd1;
	localparam logic [1:0] ERR_BODY   = 2'd2;
	localparam logic [1:0] ERR_UNEXP  = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] page_size;
		logic [1:0]  run_kind;
		logic [15:0] run_count;
		logic [7:0]  page_byte;
	} lpvd_in_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  value_byte;
		logic        value_first;
		logic        value_last;
		logic [15:0] empty_count;
		logic [1:0]  error_code;
	} lpvd_out_t;

	// classified command held in the queue between front and back
	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  run_kind;
		logic        run_empty;
		logic        run_null;
		logic        run_values;
		logic [15:0] run_count;
		logic [31:0] page_size;
		logic [7:0]  page_byte;
	} lpvd_cmd_t;

endpackage

// ===== sv/lpvd_front.sv =====
module lpvd_front import lpvd_pkg::*; #(
	parameter int RUN_COUNT_BITS = 16,
	parameter int PAGE_SIZE_BITS = 32
) (
	input  lpvd_in_t  in_data,
	output lpvd_cmd_t cmd
);

	localparam logic [15:0] RUN_MASK = (RUN_COUNT_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << RUN_COUNT_BITS) - 32'd1);
	localparam logic [31:0] PAGE_MASK = (PAGE_SIZE_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << PAGE_SIZE_BITS) - 64'd1);

	logic [15:0] count_m;

	assign count_m = in_data.run_count & RUN_MASK;

	always_comb begin
		cmd = '0;
		cmd.opcode    = in_data.opcode;
		cmd.run_kind  = in_data.run_kind;
		cmd.run_count = count_m;
		cmd.page_size = in_data.page_size & PAGE_MASK;
		cmd.page_byte = in_data.page_byte;
		cmd.run_empty = (count_m == 16'd0);
		case (in_data.run_kind)
			RK_NULL: begin
				cmd.run_null = 1'b1;
			end
			RK_CONTENT, RK_FCONTENT: begin
				cmd.run_values = 1'b1;
			end
			default: begin
				cmd.run_null   = 1'b0;
				cmd.run_values = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/lpvd_queue.sv =====
module lpvd_queue import lpvd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lpvd_cmd_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output lpvd_cmd_t head
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	lpvd_cmd_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == (PW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== sv/lpvd_back.sv =====
module lpvd_back import lpvd_pkg::*; #(
	parameter int RUN_COUNT_BITS = 16,
	parameter int PAGE_SIZE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  lpvd_cmd_t cmd,
	output logic      cmd_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output lpvd_out_t out_data
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_PREFIX = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	logic [PAGE_SIZE_BITS-1:0] bytes_q, bytes_n, bytes_dec;
	logic [1:0]                kind_q, kind_n;
	logic [RUN_COUNT_BITS-1:0] values_q, values_n, values_dec;
	logic [1:0]                phase_q, phase_n;
	logic [1:0]                seen_q, seen_n;
	logic [31:0]               acc_q, acc_n, acc_cat;
	logic [31:0]               payload_q, payload_n, payload_dec;
	logic                      err_q, err_n;

	logic      fire;
	logic      res_valid;
	lpvd_out_t res;
	logic      out_valid_q;
	lpvd_out_t out_q;

	logic      kept;
	logic      fin_end;
	logic      fin_trunc;
	logic      first;
	logic      last;

	assign fire    = cmd_valid && (!out_valid_q || !out_stall);
	assign cmd_pop = fire;

	assign bytes_dec   = bytes_q - PAGE_SIZE_BITS'(bytes_q != '0);
	assign values_dec  = values_q - RUN_COUNT_BITS'(values_q != '0);
	assign payload_dec = payload_q - 32'(payload_q != '0);
	assign acc_cat     = acc_q | (32'(cmd.page_byte) << {seen_q, 3'b000});
	assign kept        = (kind_q == RK_CONTENT);
	// end of a value: either the run is over or the next prefix does not fit in the page
	assign fin_end     = (values_dec == '0);
	assign fin_trunc   = !fin_end && (32'(bytes_dec) < 32'd4);
	assign first       = (payload_q == acc_q);
	assign last        = (payload_dec == '0);

	always_comb begin
		bytes_n   = bytes_q;
		kind_n    = kind_q;
		values_n  = values_q;
		phase_n   = phase_q;
		seen_n    = seen_q;
		acc_n     = acc_q;
		payload_n = payload_q;
		err_n     = err_q;
		res_valid = 1'b0;
		res       = '0;
		if (fire) begin
			if (cmd.opcode == OPC_START) begin
				bytes_n   = PAGE_SIZE_BITS'(cmd.page_size);
				kind_n    = RK_CONTENT;
				err_n     = 1'b0;
				phase_n   = PH_IDLE;
				values_n  = '0;
				seen_n    = '0;
				acc_n     = '0;
				payload_n = '0;
			end else if (!err_q) begin
				if (cmd.opcode == OPC_BAD || (cmd.opcode == OPC_RUN && phase_q != PH_IDLE) ||
						(cmd.opcode == OPC_BYTE && phase_q == PH_IDLE)) begin
					err_n           = 1'b1;
					phase_n         = PH_IDLE;
					values_n        = '0;
					seen_n          = '0;
					acc_n           = '0;
					payload_n       = '0;
					res_valid       = 1'b1;
					res.result_kind = RES_STATUS;
					res.error_code  = ERR_UNEXP;
				end else if (cmd.opcode == OPC_RUN) begin
					if (!cmd.run_empty) begin
						kind_n = cmd.run_kind;
						if (cmd.run_null) begin
							res_valid       = 1'b1;
							res.result_kind = RES_EMPTY;
							res.empty_count = cmd.run_count;
						end else if (cmd.run_values) begin
							values_n = RUN_COUNT_BITS'(cmd.run_count);
							phase_n  = PH_PREFIX;
							seen_n   = '0;
							acc_n    = '0;
							if (32'(bytes_q) < 32'd4) begin
								err_n           = 1'b1;
								phase_n         = PH_IDLE;
								values_n        = '0;
								payload_n       = '0;
								res_valid       = 1'b1;
								res.result_kind = RES_STATUS;
								res.error_code  = ERR_PREFIX;
							end
						end
					end
				end else begin
					bytes_n = bytes_dec;
					if (phase_q == PH_PREFIX) begin
						seen_n = seen_q + 2'd1;
						acc_n  = acc_cat;
						if (seen_q == 2'd3) begin
							if (acc_cat > 32'(bytes_dec)) begin
								err_n           = 1'b1;
								phase_n         = PH_IDLE;
								values_n        = '0;
								seen_n          = '0;
								acc_n           = '0;
								payload_n       = '0;
								res_valid       = 1'b1;
								res.result_kind = RES_STATUS;
								res.error_code  = ERR_BODY;
							end else if (acc_cat == '0) begin
								seen_n    = '0;
								acc_n     = '0;
								payload_n = '0;
								if (fin_end || fin_trunc) begin
									phase_n  = PH_IDLE;
									values_n = '0;
									err_n    = fin_trunc;
								end else begin
									phase_n  = PH_PREFIX;
									values_n = values_dec;
								end
								if (kept) begin
									res_valid       = 1'b1;
									res.result_kind = RES_EMPTY;
									res.empty_count = 16'd1;
									res.error_code  = fin_trunc ? ERR_PREFIX : ERR_NONE;
								end else if (fin_trunc) begin
									res_valid       = 1'b1;
									res.result_kind = RES_STATUS;
									res.error_code  = ERR_PREFIX;
								end
							end else begin
								phase_n   = PH_BODY;
								payload_n = acc_cat;
							end
						end
					end else begin
						payload_n = payload_dec;
						if (last) begin
							seen_n    = '0;
							acc_n     = '0;
							payload_n = '0;
							if (fin_end || fin_trunc) begin
								phase_n  = PH_IDLE;
								values_n = '0;
								err_n    = fin_trunc;
							end else begin
								phase_n  = PH_PREFIX;
								values_n = values_dec;
							end
						end
						if (kept) begin
							res_valid       = 1'b1;
							res.result_kind = RES_DATA;
							res.value_byte  = cmd.page_byte;
							res.value_first = first;
							res.value_last  = last;
							res.error_code  = (last && fin_trunc) ? ERR_PREFIX : ERR_NONE;
						end else if (last && fin_trunc) begin
							res_valid       = 1'b1;
							res.result_kind = RES_STATUS;
							res.error_code  = ERR_PREFIX;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q     <= '0;
			kind_q      <= RK_CONTENT;
			values_q    <= '0;
			phase_q     <= PH_IDLE;
			seen_q      <= '0;
			acc_q       <= '0;
			payload_q   <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			bytes_q   <= bytes_n;
			kind_q    <= kind_n;
			values_q  <= values_n;
			phase_q   <= phase_n;
			seen_q    <= seen_n;
			acc_q     <= acc_n;
			payload_q <= payload_n;
			err_q     <= err_n;
			if (fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/length_prefixed_value_deframer_unit.sv =====
// Streams a page of length-prefixed values (4-byte little-endian length, then the payload)
// under run commands, and emits kept payload bytes with first/last marks, empty-value counts
// for null runs and zero-length kept values, and sticky error codes. Every input beat, be it
// start page, run command or page byte, is taken by the back-end parser in its state update,
// so one beat per cycle is sustained while the output is not stalled. An accepted beat is
// registered in a two-entry command queue after the classifying front end and again in the
// registered output after the parser.
module length_prefixed_value_deframer_unit import lpvd_pkg::*; #(
	parameter int RUN_COUNT_BITS = 16,
	parameter int PAGE_SIZE_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lpvd_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output lpvd_out_t out_data
);

	lpvd_cmd_t cmd_in;
	lpvd_cmd_t cmd_head;
	logic      q_full;
	logic      q_not_empty;
	logic      q_pop;

	assign in_stall = q_full;

	lpvd_front #(
		.RUN_COUNT_BITS(RUN_COUNT_BITS),
		.PAGE_SIZE_BITS(PAGE_SIZE_BITS)
	) u_front (
		.in_data(in_data),
		.cmd    (cmd_in)
	);

	lpvd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_data(cmd_in),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (cmd_head)
	);

	lpvd_back #(
		.RUN_COUNT_BITS(RUN_COUNT_BITS),
		.PAGE_SIZE_BITS(PAGE_SIZE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_not_empty),
		.cmd      (cmd_head),
		.cmd_pop  (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
